/* rtl/core/chained_hash_table_unit_assert.svh */
// assertion macros for the chained hash table unit
`ifndef CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
`define CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CHT_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define CHT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CHT_ASSERT_IMPL(label, clk, rst, a, c)
`define CHT_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* rtl/core/cht_pkg.sv */
// ----------------------------------------------------------------------------
// cht_pkg
// widths and codes shared by the chained hash table unit
// ----------------------------------------------------------------------------
package cht_pkg;
  localparam int Buckets = 128;
  localparam int Nodes = 128;
  localparam int NodeBits = $clog2(Nodes + 1);
  localparam int BktBits = $clog2(Buckets);
  localparam logic [NodeBits-1:0] NilNode = NodeBits'(Nodes);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_FOUND = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DELETED = 3'd4;
  localparam logic [2:0] ST_DEL_MISS = 3'd5;
endpackage

/* rtl/core/chained_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// chained_hash_table_unit
// hash table with separate chaining over a fixed node pool
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass over all buckets and nodes builds the
// free list and empties the bucket heads; busy stays high meanwhile. A request
// then runs the bit-serial modulo (one quotient bit a cycle), a head read and
// decision, a memory read per chain node visited, a node release on a delete
// hit or a free-list pop on an insert, and then the result. The result
// strobe is high for one cycle and cannot be stalled.
module chained_hash_table_unit
  import cht_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [6:0]  bucket,
  output logic [7:0]  entry_total
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MOD = 4'd2;
  localparam logic [3:0] S_HEAD = 4'd3;
  localparam logic [3:0] S_HEADW = 4'd4;
  localparam logic [3:0] S_NODE = 4'd5;
  localparam logic [3:0] S_NODEW = 4'd6;
  localparam logic [3:0] S_FREE = 4'd7;
  localparam logic [3:0] S_FREEW = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state;
  logic [7:0] bucket_count;
  logic [7:0] nb;
  logic [NodeBits-1:0] cap;

  logic [NodeBits-1:0] heads [Buckets];
  logic [31:0] vals [Nodes];
  logic [NodeBits-1:0] links [Nodes];

  logic [NodeBits-1:0] free_head;
  logic [NodeBits-1:0] stored;
  logic [1:0] act;
  logic [31:0] key;
  logic [31:0] quo;
  logic [7:0] rem;
  logic [5:0] cnt;
  logic [BktBits-1:0] bkt;
  logic [NodeBits-1:0] cur, prev;
  logic [NodeBits:0] steps;
  logic [NodeBits-1:0] hd_q;
  logic [31:0] val_q;
  logic [NodeBits-1:0] lnk_q;
  logic [2:0] st;
  logic [8:0] rem_sh;
  logic [BktBits-1:0] clr_idx;

  assign nb = (bucket_count == 8'd0) ? 8'd1 :
              (bucket_count > 8'(Buckets)) ? 8'(Buckets) : bucket_count;
  assign cap = (nb < 8'(Nodes)) ? NodeBits'(nb) : NodeBits'(Nodes);
  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign rem_sh = {rem, quo[31]};

  // bucket heads
  always_ff @(posedge clk) begin
    hd_q <= heads[(state == S_HEAD) ? rem[BktBits-1:0] : bkt];
    if (state == S_CLEAR) begin
      heads[clr_idx] <= NilNode;
    end else if (state == S_FREEW && act == ACT_INSERT) begin
      heads[bkt] <= cur;
    end else if (state == S_NODEW && act == ACT_DELETE && val_q == key
                 && prev == NilNode) begin
      heads[bkt] <= lnk_q;
    end
  end

  // node values and links
  always_ff @(posedge clk) begin
    val_q <= vals[cur[BktBits-1:0]];
    lnk_q <= links[cur[BktBits-1:0]];
    if (state == S_CLEAR) begin
      links[clr_idx] <= NodeBits'(clr_idx) + NodeBits'(1);
    end else if (state == S_FREEW && act == ACT_INSERT) begin
      vals[cur[BktBits-1:0]] <= key;
      links[cur[BktBits-1:0]] <= hd_q;
    end else if (state == S_NODEW && act == ACT_DELETE && val_q == key
                 && prev != NilNode) begin
      links[prev[BktBits-1:0]] <= lnk_q;
    end else if (state == S_FREE && act == ACT_DELETE) begin
      links[cur[BktBits-1:0]] <= free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      bucket_count <= 8'd128;
      free_head <= '0;
      stored <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        bucket_count <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + BktBits'(1);
          if (clr_idx == BktBits'(Buckets - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            act <= action;
            key <= value;
            quo <= value;
            rem <= '0;
            cnt <= '0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (rem_sh >= {1'b0, nb}) begin
            rem <= 8'(rem_sh - {1'b0, nb});
          end else begin
            rem <= rem_sh[7:0];
          end
          quo <= {quo[30:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) state <= S_HEAD;
        end
        S_HEAD: begin
          bkt <= rem[BktBits-1:0];
          state <= S_HEADW;
        end
        S_HEADW: begin
          prev <= NilNode;
          steps <= '0;
          if (act == ACT_INSERT) begin
            if (stored >= cap || free_head == NilNode) begin
              st <= ST_FULL;
              state <= S_DONE;
            end else begin
              cur <= free_head;
              state <= S_FREE;
            end
          end else begin
            st <= (act == ACT_DELETE) ? ST_DEL_MISS : ST_NOT_FOUND;
            cur <= hd_q;
            state <= (hd_q == NilNode) ? S_DONE : S_NODE;
          end
        end
        S_NODE: state <= S_NODEW;
        S_NODEW: begin
          if (val_q == key) begin
            if (act == ACT_DELETE) begin
              st <= ST_DELETED;
              state <= S_FREE;
            end else begin
              st <= ST_FOUND;
              state <= S_DONE;
            end
          end else begin
            prev <= cur;
            cur <= lnk_q;
            steps <= steps + (NodeBits + 1)'(1);
            if (lnk_q == NilNode || steps == (NodeBits + 1)'(Nodes - 1)) begin
              state <= S_DONE;
            end else begin
              state <= S_NODE;
            end
          end
        end
        S_FREE: begin
          if (act == ACT_DELETE) begin
            free_head <= cur;
            if (stored != '0) stored <= stored - NodeBits'(1);
            state <= S_DONE;
          end else begin
            state <= S_FREEW;
          end
        end
        S_FREEW: begin
          free_head <= lnk_q;
          stored <= stored + NodeBits'(1);
          st <= ST_INSERTED;
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          status <= st;
          bucket <= 7'(bkt);
          entry_total <= 8'(stored);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "chained_hash_table_unit_assert.svh"
  `CHT_ASSERT_IMPL(a_cap, clk, rst, 1'b1, stored <= NodeBits'(Nodes))
  `CHT_ASSERT_NEXT(a_done_idle, clk, rst, done, !done)
  `CHT_ASSERT_IMPL(a_cfg_idle, clk, rst, cfg_valid && cfg_ready, !busy)
endmodule
